### src/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, codes and constants for the partitioned multi-stack memory.
// ----------------------------------------------------------------------------
package msp_pkg;

    // default parameter values
    localparam int DEF_MEM_DEPTH  = 64;
    localparam int DEF_MAX_STACKS = 8;
    localparam int DEF_DATA_WIDTH = 32;

    // field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 3;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 4;
    localparam int SIZE_W  = 7;
    localparam int FILL_W  = 7;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 7;

    // widest unreduced word address: 7*127 + 126 < 1024
    localparam int SUM_W = 10;

    localparam logic [CNT_W-1:0]  RST_STACK_COUNT = CNT_W'(8);
    localparam logic [SIZE_W-1:0] RST_STACK_SIZE  = SIZE_W'(8);

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_STACK_COUNT = CFG_A_W'(0);
    localparam logic [CFG_A_W-1:0] CFG_STACK_SIZE  = CFG_A_W'(1);

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH    = OP_W'(0);
    localparam logic [OP_W-1:0] OP_POP     = OP_W'(1);
    localparam logic [OP_W-1:0] OP_DISPLAY = OP_W'(2);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OVER    = 2'd1,
        ST_UNDER   = 2'd2,
        ST_NOSTACK = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_REDUCE,
        S_MEM,
        S_LOAD,
        S_OUT
    } t_state;

    // address unit commands
    typedef struct packed {
        logic load;
        logic next;
    } t_red_ctl;

    // memory port commands
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_ctl;

endpackage

### src/msp_mem.sv
// ----------------------------------------------------------------------------
// msp_mem
// Single-port word memory holding all stack regions, registered read data.
// ----------------------------------------------------------------------------
module msp_mem #(
    parameter int MEM_DEPTH  = msp_pkg::DEF_MEM_DEPTH,
    parameter int DATA_WIDTH = msp_pkg::DEF_DATA_WIDTH,
    localparam int AW        = $clog2(MEM_DEPTH)
) (
    input  logic                  i_clk,
    input  msp_pkg::t_mem_ctl     i_ctl,
    input  logic [AW-1:0]         i_addr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    output logic [DATA_WIDTH-1:0] o_rdata
);
    import msp_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/msp_addr_unit.sv
// ----------------------------------------------------------------------------
// msp_addr_unit
// Shared address unit: reduces a word address modulo the memory depth by
// reciprocal multiply then multiply back and subtract, and steps it with wrap.
// ----------------------------------------------------------------------------
module msp_addr_unit #(
    parameter int MEM_DEPTH = msp_pkg::DEF_MEM_DEPTH,
    localparam int AW       = $clog2(MEM_DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  msp_pkg::t_red_ctl        i_ctl,
    input  logic [msp_pkg::SUM_W-1:0] i_x,
    output logic                     o_busy,
    output logic [AW-1:0]            o_addr
);
    import msp_pkg::*;

    localparam int XW = (SUM_W > AW) ? SUM_W : AW;
    // scale and reciprocal give an exact quotient for every SUM_W-bit address
    localparam int RS = SUM_W + AW;
    localparam int MW = SUM_W + 2;
    localparam int PW = XW + MW;
    localparam logic [MW-1:0] RECIP = MW'(((1 << RS) + MEM_DEPTH - 1) / MEM_DEPTH);

    logic [XW-1:0]    r_x;
    logic [SUM_W-1:0] r_q;
    logic             r_stage;
    logic             r_busy;
    logic [PW-1:0]    w_prod;
    logic [SUM_W-1:0] w_quo;
    logic [XW-1:0]    w_back;

    assign w_prod = PW'(r_x) * PW'(RECIP);
    assign w_quo  = SUM_W'(w_prod >> RS);
    assign w_back = XW'(r_q) * XW'(MEM_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_stage) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x     <= XW'(i_x);
            r_stage <= 1'b0;
        end else if (i_ctl.next) begin
            // advance to the next word, wrap at the end of memory
            r_x <= (r_x == XW'(MEM_DEPTH - 1)) ? '0 : XW'(r_x + 1'b1);
        end else if (r_busy) begin
            if (!r_stage) begin
                r_q     <= w_quo;
                r_stage <= 1'b1;
            end else begin
                // drop whole multiples of the depth
                r_x <= r_x - w_back;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_addr = AW'(r_x);

endmodule

### src/multi_stack_partitioned_memory_top.sv
// ----------------------------------------------------------------------------
// multi_stack_partitioned_memory_top
// Several stacks in one word memory, one equal region per stack; push, pop
// and display requests under a small sequencer.
//
//  channel   direction  handshake                 payload
//  request   in         i_valid / o_ready         i_opcode, i_stack_index,
//                                                 i_push_value
//  result    out        o_valid / i_ready         o_status, o_read_value, o_last
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each request passes through a decode state; a missing stack, overflow or
// underflow result goes from there straight to the result state. Otherwise
// the shared address unit reduces the address (reciprocal multiply, then
// multiply back and subtract) while the sequencer waits; then a memory state
// writes a push, or reads for a pop or display and a load state captures
// the word. Display repeats read, load and present for each further entry
// once the previous result is taken. o_ready is high only while idle, from
// the cycle after the final result is taken. Reset is synchronous active low;
// it resets only fill counts, state and configuration, not the memory.
// ----------------------------------------------------------------------------
module multi_stack_partitioned_memory_top #(
    parameter int MEM_DEPTH  = msp_pkg::DEF_MEM_DEPTH,
    parameter int MAX_STACKS = msp_pkg::DEF_MAX_STACKS,
    parameter int DATA_WIDTH = msp_pkg::DEF_DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [msp_pkg::OP_W-1:0]      i_opcode,
    input  logic [msp_pkg::IDX_W-1:0]     i_stack_index,
    input  logic signed [msp_pkg::VAL_W-1:0] i_push_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic signed [msp_pkg::VAL_W-1:0] o_read_value,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [msp_pkg::CFG_A_W-1:0]   i_cfg_index,
    input  logic [msp_pkg::CFG_D_W-1:0]   i_cfg_data
);
    import msp_pkg::*;

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int FIW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;

    t_state             r_state, n_state;
    logic [OP_W-1:0]    r_op;
    logic [IDX_W-1:0]   r_k;
    logic [VAL_W-1:0]   r_val;
    logic [CNT_W-1:0]   r_count;
    logic [SIZE_W-1:0]  r_size;
    logic [FILL_W-1:0]  r_fill [MAX_STACKS];
    logic [FILL_W-1:0]  r_left, n_left;
    t_status            r_status, n_status;
    logic [VAL_W-1:0]   r_value, n_value;
    logic               r_last, n_last;

    logic               w_in_acc;
    logic [FIW-1:0]     w_fidx;
    logic [FILL_W-1:0]  w_fill;
    logic               w_nostack;
    logic [SIZE_W-1:0]  w_cap;
    logic [SUM_W-1:0]   w_base;
    logic [SUM_W-1:0]   w_red_x;
    logic               w_fill_we;
    logic [FILL_W-1:0]  w_fill_wdata;
    t_red_ctl           w_red_ctl;
    t_mem_ctl           w_mem_ctl;
    logic               w_red_busy;
    logic [AW-1:0]      w_addr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [63:0]        w_rd64;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && o_ready;

    assign w_fidx    = FIW'(r_k);
    assign w_fill    = r_fill[w_fidx];
    assign w_nostack = ({1'b0, r_k} >= r_count) || (32'(r_k) >= MAX_STACKS);
    assign w_cap     = (32'(r_size) > MEM_DEPTH) ? SIZE_W'(MEM_DEPTH) : r_size;
    assign w_base    = SUM_W'(r_k) * SUM_W'(r_size);
    assign w_wdata   = DATA_WIDTH'(64'(r_val));
    assign w_rd64    = 64'(w_rdata);

    msp_addr_unit #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_addr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_red_ctl),
        .i_x    (w_red_x),
        .o_busy (w_red_busy),
        .o_addr (w_addr)
    );

    msp_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_ctl  (w_mem_ctl),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= RST_STACK_COUNT;
            r_size  <= RST_STACK_SIZE;
            for (int i = 0; i < MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STACK_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                    CFG_STACK_SIZE:  r_size  <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (w_fill_we) begin
                r_fill[w_fidx] <= w_fill_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= i_opcode;
            r_k   <= i_stack_index;
            r_val <= i_push_value;
        end
        r_left   <= n_left;
        r_status <= n_status;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    always_comb begin
        n_state      = r_state;
        n_left       = r_left;
        n_status     = r_status;
        n_value      = r_value;
        n_last       = r_last;
        w_red_ctl    = '0;
        w_mem_ctl    = '0;
        w_red_x      = w_base;
        w_fill_we    = 1'b0;
        w_fill_wdata = w_fill;

        case (r_state)
            S_IDLE: begin
                // unknown opcodes are taken and dropped
                if (w_in_acc && (i_opcode inside {OP_PUSH, OP_POP, OP_DISPLAY})) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_value = '0;
                n_last  = 1'b1;
                n_left  = FILL_W'(1);
                if (w_nostack) begin
                    n_status = ST_NOSTACK;
                    n_state  = S_OUT;
                end else begin
                    case (r_op)
                        OP_PUSH: begin
                            if (w_fill >= w_cap) begin
                                n_status = ST_OVER;
                                n_state  = S_OUT;
                            end else begin
                                w_red_x        = w_base + SUM_W'(w_fill);
                                w_red_ctl.load = 1'b1;
                                n_state        = S_REDUCE;
                            end
                        end
                        OP_POP: begin
                            if (w_fill == '0) begin
                                n_status = ST_UNDER;
                                n_state  = S_OUT;
                            end else begin
                                w_fill_we      = 1'b1;
                                w_fill_wdata   = w_fill - 1'b1;
                                w_red_x        = w_base + SUM_W'(w_fill - 1'b1);
                                w_red_ctl.load = 1'b1;
                                n_state        = S_REDUCE;
                            end
                        end
                        OP_DISPLAY: begin
                            if (w_fill == '0) begin
                                n_status = ST_UNDER;
                                n_state  = S_OUT;
                            end else begin
                                n_left         = w_fill;
                                w_red_ctl.load = 1'b1;
                                n_state        = S_REDUCE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_REDUCE: begin
                if (!w_red_busy) begin
                    n_state = S_MEM;
                end
            end
            S_MEM: begin
                if (r_op == OP_PUSH) begin
                    w_mem_ctl.wr = 1'b1;
                    w_fill_we    = 1'b1;
                    w_fill_wdata = w_fill + 1'b1;
                    n_status     = ST_OK;
                    n_value      = '0;
                    n_last       = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    w_mem_ctl.rd = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                n_status = ST_OK;
                n_value  = w_rd64[VAL_W-1:0];
                n_last   = (r_left == FILL_W'(1));
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // advance to the next display entry
                        n_left         = r_left - 1'b1;
                        w_red_ctl.next = 1'b1;
                        n_state        = S_MEM;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid      = (r_state == S_OUT);
    assign o_status     = r_status;
    assign o_read_value = r_value;
    assign o_last       = r_last;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("request taken while a result is pending");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_last && o_read_value == '0))
        else $error("error result not final or carries data");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEM) |-> (32'(w_addr) < MEM_DEPTH && !w_red_busy))
        else $error("memory address out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> o_ready)
        else $error("not idle after final result");
`endif

endmodule
